FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: hw/rtl/ahpd_pkg.sv
`default_nettype none
package ahpd_pkg;

  localparam int STORE_DEPTH_DEF = 16;
  localparam int MIN_PACKET      = 6;
  localparam logic [7:0] START_RESET = 8'd60;
  localparam logic [7:0] STOP_RESET  = 8'd62;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [3:0] HEX_TEN = 4'd10;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_STOP  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OVERFLOW     = 3'd1,
    ST_SHORT        = 3'd2,
    ST_BAD_SIZE     = 3'd3,
    ST_BAD_TYPE     = 3'd4,
    ST_LEN_MISMATCH = 3'd5,
    ST_BAD_HEX      = 3'd6,
    ST_CHECKSUM     = 3'd7
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] body_len;
    logic [3:0] pkt_type;
  } chk_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  // bit 4 set: not a hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (is_digit(c)) begin
      d = c - CHAR_0;
      return {1'b0, d[3:0]};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - CHAR_UA;
      return {1'b0, d[3:0] + HEX_TEN};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      d = c - CHAR_LA;
      return {1'b0, d[3:0] + HEX_TEN};
    end
    return 5'h10;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ahpd_check.sv
`default_nettype none
module ahpd_check import ahpd_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic [$clog2(STORE_DEPTH)-1:0] count,
  input  wire logic [7:0]                     size_c,
  input  wire logic [7:0]                     type_c,
  input  wire logic [7:0]                     prev1,
  input  wire logic [7:0]                     prev2,
  input  wire logic [7:0]                     run,
  output chk_t                                chk
);

  localparam int CNT_W = $clog2(STORE_DEPTH);
  localparam int CMP_W = ((CNT_W > 4) ? CNT_W : 4) + 1;

  logic [CMP_W-1:0] n;
  logic [7:0]       len8;
  logic [7:0]       type8;
  logic [4:0]       hi;
  logic [4:0]       lo;
  logic [7:0]       sum;

  always_comb begin
    // count is the index the stop byte lands on; n is the full packet length
    n     = CMP_W'(count) + CMP_W'(1);
    len8  = size_c - CHAR_0;
    type8 = type_c - CHAR_0;
    hi    = hex_value(prev2);
    lo    = hex_value(prev1);
    // drop the two checksum characters from the running XOR
    sum   = run ^ prev1 ^ prev2;

    chk.body_len = len8[3:0];
    chk.pkt_type = type8[3:0];
    if (n < CMP_W'(MIN_PACKET)) begin
      chk.status = ST_SHORT;
    end else if (!is_digit(size_c)) begin
      chk.status = ST_BAD_SIZE;
    end else if (!is_digit(type_c)) begin
      chk.status = ST_BAD_TYPE;
    end else if (n != CMP_W'(len8[3:0]) + CMP_W'(MIN_PACKET)) begin
      chk.status = ST_LEN_MISMATCH;
    end else if (hi[4] || lo[4]) begin
      chk.status = ST_BAD_HEX;
    end else if (sum != {hi[3:0], lo[3:0]}) begin
      chk.status = ST_CHECKSUM;
    end else begin
      chk.status = ST_OK;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ascii_hex_packet_deframer_core.sv
// Delimited packet deframer with XOR checksum.
// Input channel: rx_byte with in_valid / in_stall, one word per accepted byte.
// Output channel: status, pkt_type, body_count, body_byte, byte_valid, last
// with out_valid / out_stall, all from one output register.
// Config: cfg_wen writes cfg_data[7:0] to start byte (index 0) or stop byte
// (index 1); write only while idle.
// Bytes are accepted one per cycle while hunting or collecting and the output
// is not stalled. A byte that ends a packet in error, or an accepted packet
// with an empty body, gives its word in the output register in the next cycle.
// An accepted packet with a body is read back from the packet store, one
// memory read (S_READ) then one output load (S_LOAD) per body byte; a load
// waits while the output register is full and stalled. The input is
// stalled during that readback.
// When the output register is full and stalled, the input is stalled too.
// Reset (rst, synchronous) empties the output, restores start '<' and stop
// '>' and starts hunting; the store needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module ascii_hex_packet_deframer_core import ahpd_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      status,
  output logic [3:0]      pkt_type,
  output logic [3:0]      body_count,
  output logic [7:0]      body_byte,
  output logic            byte_valid,
  output logic            last
);

  localparam int CNT_W = $clog2(STORE_DEPTH);

  typedef enum logic [3:0] {
    S_HUNT    = 4'b0001,
    S_COLLECT = 4'b0010,
    S_READ    = 4'b0100,
    S_LOAD    = 4'b1000
  } state_t;

  state_t           state;
  logic [7:0]       start_byte;
  logic [7:0]       stop_byte;
  logic [CNT_W-1:0] count;
  logic [7:0]       size_c;
  logic [7:0]       type_c;
  logic [7:0]       prev1;
  logic [7:0]       prev2;
  logic [7:0]       run;
  logic [3:0]       idx;
  logic [3:0]       blen;
  logic [3:0]       btype;
  logic [7:0]       rd_data;
  logic [7:0]       store [STORE_DEPTH];

  chk_t             chk;
  logic             accept_in;
  logic             out_take;
  logic             out_free;
  logic             out_load;
  logic             store_full;
  logic             wr_en;
  logic             idx_last;
  logic [CNT_W-1:0] rd_addr;

  ahpd_check #(.STORE_DEPTH(STORE_DEPTH)) u_check (
    .count  (count),
    .size_c (size_c),
    .type_c (type_c),
    .prev1  (prev1),
    .prev2  (prev2),
    .run    (run),
    .chk    (chk)
  );

  assign in_stall   = ((state != S_HUNT) && (state != S_COLLECT)) || (out_valid && out_stall);
  assign accept_in  = in_valid && !in_stall;
  assign out_take   = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;
  assign store_full = (count == CNT_W'(STORE_DEPTH - 1));
  assign wr_en      = accept_in && (state == S_COLLECT) && !store_full;
  assign idx_last   = (idx == blen - 4'd1);
  assign rd_addr    = CNT_W'(3) + CNT_W'(idx);
  // a new word enters the output register this cycle
  assign out_load   = ((state == S_COLLECT) && accept_in &&
                       (store_full || ((rx_byte == stop_byte) &&
                        ((chk.status != ST_OK) || (chk.body_len == 4'd0))))) ||
                      ((state == S_LOAD) && out_free);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[count] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
      stop_byte  <= STOP_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_START: start_byte <= cfg_data;
        CFG_STOP:  stop_byte  <= cfg_data;
        default:   start_byte <= start_byte;
      endcase
    end
  end

  // start byte clears checksum; stored bytes shift history and XOR into it
  always_ff @(posedge clk) begin
    if (accept_in && (state == S_HUNT) && (rx_byte == start_byte)) begin
      run <= 8'd0;
    end else if (wr_en) begin
      prev2 <= prev1;
      prev1 <= rx_byte;
      run   <= run ^ rx_byte;
      if (count == CNT_W'(1)) begin
        size_c <= rx_byte;
      end
      if (count == CNT_W'(2)) begin
        type_c <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_HUNT;
      count     <= '0;
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_HUNT: begin
          if (accept_in && (rx_byte == start_byte)) begin
            count <= CNT_W'(1);
            state <= S_COLLECT;
          end
        end
        S_COLLECT: begin
          if (accept_in) begin
            if (store_full) begin
              // drop the byte, report overflow
              state       <= S_HUNT;
              status      <= ST_OVERFLOW;
              pkt_type    <= 4'd0;
              body_count  <= 4'd0;
              body_byte   <= 8'd0;
              byte_valid  <= 1'b0;
              last        <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
              if (rx_byte == stop_byte) begin
                state <= S_HUNT;
                if (chk.status != ST_OK) begin
                  status      <= chk.status;
                  pkt_type    <= 4'd0;
                  body_count  <= 4'd0;
                  body_byte   <= 8'd0;
                  byte_valid  <= 1'b0;
                  last        <= 1'b1;
                end else if (chk.body_len == 4'd0) begin
                  status      <= ST_OK;
                  pkt_type    <= chk.pkt_type;
                  body_count  <= 4'd0;
                  body_byte   <= 8'd0;
                  byte_valid  <= 1'b0;
                  last        <= 1'b1;
                end else begin
                  state <= S_READ;
                  idx   <= 4'd0;
                  blen  <= chk.body_len;
                  btype <= chk.pkt_type;
                end
              end
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          // hold the read word until the output register frees up
          if (out_free) begin
            status      <= ST_OK;
            pkt_type    <= btype;
            body_count  <= blen;
            body_byte   <= rd_data;
            byte_valid  <= 1'b1;
            last        <= idx_last;
            idx         <= idx + 4'd1;
            state       <= idx_last ? S_HUNT : S_READ;
          end
        end
        default: begin
          state <= S_HUNT;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_status_word_last, out_valid && !byte_valid |-> last, "status word without last")
  `ASSERT_CLK(a_body_word_ok,
              out_valid && byte_valid |-> (status == ST_OK) && (body_count != 4'd0),
              "body word with bad status")
  `ASSERT_CLK(a_stop_ends_collect,
              accept_in && (state == S_COLLECT) && (rx_byte == stop_byte) |=> (state != S_COLLECT),
              "stop byte did not end packet")
  `ASSERT_CLK(a_load_fills_output, (state == S_LOAD) && !out_valid |=> out_valid, "body word not loaded")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && (state == S_HUNT), "reset left block busy")

endmodule
`default_nettype wire
